>>> src/cpg_pkg.sv
// Package for the circle point generator: field widths, codes and shared types.
// No dependencies; used by circle_point_generator.
package cpg_pkg;

  localparam int unsigned CoordInW   = 10;  // center row/col and radius
  localparam int unsigned ColorW     = 24;
  localparam int unsigned CfgW       = 11;  // image size registers
  localparam int unsigned PixW       = 12;  // signed output coordinates
  localparam int unsigned DecW       = 16;  // midpoint decision variable
  localparam int unsigned SDataW     = 56;  // 54 bits of fields, padded to bytes
  localparam int unsigned MDataW     = 48;
  localparam int unsigned MUserW     = 2;
  localparam int unsigned MaxSideDef = 1024;
  localparam int unsigned SizeRstVal = 1024;

  typedef logic signed [PixW-1:0] coord_t;
  typedef logic signed [DecW-1:0] dec_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    REG_IMAGE_HEIGHT = 1'b0,
    REG_IMAGE_WIDTH  = 1'b1
  } cfg_reg_e;

endpackage

>>> src/circle_point_generator.sv
// Midpoint circle point generator, top level.
// Depends on cpg_pkg for widths, operation and register codes.
//
// Each accepted start, or advance of a running circle, yields eight points,
// one per cycle while the output is not stalled; the next item is taken in
// the cycle its predecessor's eighth point moves into the output register.
// Outputs are registered; the decision update is done in the accepting
// cycle. An advance with no circle running is accepted, changes nothing
// and produces no output.
module circle_point_generator #(
  parameter int unsigned MAX_SIDE = cpg_pkg::MaxSideDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [cpg_pkg::CfgW-1:0]   cfg_wdata_i,
  // input stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: center_row[9:0], center_col[19:10], radius[29:20], color[53:30], zero pad
  input  logic [cpg_pkg::SDataW-1:0] s_axis_tdata_i,
  // tuser: op
  input  logic                       s_axis_tuser_i,
  // output stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tdata: pixel_row[11:0], pixel_col[23:12], pixel_color[47:24]
  output logic [cpg_pkg::MDataW-1:0] m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  // tuser: outside[0], done_res[1]
  output logic [cpg_pkg::MUserW-1:0] m_axis_tuser_o
);

  import cpg_pkg::*;

  localparam int unsigned EW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned CmpW = (EW > 12) ? EW + 1 : 13;
  localparam int unsigned RstSize = (SizeRstVal > MAX_SIDE) ? MAX_SIDE : SizeRstVal;

  // configuration, stored already clamped to MAX_SIDE
  logic [EW-1:0] eff_h_q, eff_w_q;
  logic [EW-1:0] cfg_sat;
  logic          cfg_over;

  assign cfg_over = {{(CmpW-CfgW){1'b0}}, cfg_wdata_i} > CmpW'(MAX_SIDE);
  assign cfg_sat  = cfg_over ? EW'(MAX_SIDE) : EW'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_h_q <= EW'(RstSize);
      eff_w_q <= EW'(RstSize);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_IMAGE_HEIGHT: eff_h_q <= cfg_sat;
        REG_IMAGE_WIDTH:  eff_w_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  // circle state; also the source of the points being emitted
  logic                  active_q, active_d;
  logic [CoordInW-1:0]   ctr_row_q, ctr_row_d;
  logic [CoordInW-1:0]   ctr_col_q, ctr_col_d;
  logic [ColorW-1:0]     color_q, color_d;
  coord_t                x_q, x_d, y_q, y_d;
  dec_t                  dec_q, dec_d;
  logic                  fin_q, fin_d;
  logic                  busy_q, busy_d;
  logic [2:0]            k_q, k_d;

  logic out_free, emit_move, emit_last, in_fire;
  logic                m_valid_q, m_valid_d;
  logic [MDataW-1:0]   m_data_q, m_data_d;
  logic                m_last_q, m_last_d;
  logic [MUserW-1:0]   m_user_q, m_user_d;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign emit_move       = busy_q && out_free;
  assign emit_last       = emit_move && (k_q == 3'd7);
  assign s_axis_tready_o = !busy_q || emit_last;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // input fields
  logic [CoordInW-1:0] in_row, in_col, in_rad;
  logic [ColorW-1:0]   in_color;
  assign in_row   = s_axis_tdata_i[9:0];
  assign in_col   = s_axis_tdata_i[19:10];
  assign in_rad   = s_axis_tdata_i[29:20];
  assign in_color = s_axis_tdata_i[53:30];

  // one midpoint step
  coord_t x_nx, y_nx, diff;
  dec_t   dec_nx, dec_init;
  logic   dec_pos;

  assign dec_pos  = dec_q > $signed(DecW'(0));
  assign x_nx     = x_q + coord_t'(1);
  assign y_nx     = dec_pos ? (y_q - coord_t'(1)) : y_q;
  assign diff     = dec_pos ? (x_nx - y_nx) : x_nx;
  assign dec_nx   = dec_q + {{(DecW-PixW-2){diff[PixW-1]}}, diff, 2'b00}
                  + (dec_pos ? dec_t'(10) : dec_t'(6));
  assign dec_init = dec_t'(3) - {{(DecW-CoordInW-1){1'b0}}, in_rad, 1'b0};

  always_comb begin
    active_d  = active_q;
    ctr_row_d = ctr_row_q;
    ctr_col_d = ctr_col_q;
    color_d   = color_q;
    x_d       = x_q;
    y_d       = y_q;
    dec_d     = dec_q;
    fin_d     = fin_q;
    busy_d    = busy_q && !emit_last;
    k_d       = emit_move ? k_q + 3'd1 : k_q;
    if (in_fire) begin
      if (op_e'(s_axis_tuser_i) == OP_START) begin
        active_d  = 1'b1;
        ctr_row_d = in_row;
        ctr_col_d = in_col;
        color_d   = in_color;
        x_d       = '0;
        y_d       = {{(PixW-CoordInW){1'b0}}, in_rad};
        dec_d     = dec_init;
        fin_d     = 1'b0;
        busy_d    = 1'b1;
        k_d       = '0;
      end else if (active_q) begin
        x_d      = x_nx;
        y_d      = y_nx;
        dec_d    = dec_nx;
        fin_d    = y_nx < x_nx;
        active_d = !(y_nx < x_nx);
        busy_d   = 1'b1;
        k_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      busy_q   <= 1'b0;
      k_q      <= '0;
      fin_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      busy_q   <= busy_d;
      k_q      <= k_d;
      fin_q    <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_row_q <= ctr_row_d;
    ctr_col_q <= ctr_col_d;
    color_q   <= color_d;
    x_q       <= x_d;
    y_q       <= y_d;
    dec_q     <= dec_d;
  end

  // point k of the octant pattern: bit 2 swaps x/y, bit 0 negates the row
  // offset, bit 1 the column offset
  coord_t a_sel, b_sel, pt_row, pt_col, r_ext, c_ext;
  logic   pt_out;

  assign r_ext  = {{(PixW-CoordInW){1'b0}}, ctr_row_q};
  assign c_ext  = {{(PixW-CoordInW){1'b0}}, ctr_col_q};
  assign a_sel  = k_q[2] ? y_q : x_q;
  assign b_sel  = k_q[2] ? x_q : y_q;
  assign pt_row = k_q[0] ? (r_ext - a_sel) : (r_ext + a_sel);
  assign pt_col = k_q[1] ? (c_ext - b_sel) : (c_ext + b_sel);
  assign pt_out = pt_row[PixW-1] || pt_col[PixW-1]
               || ({{(CmpW-PixW){1'b0}}, pt_row} >= {{(CmpW-EW){1'b0}}, eff_h_q})
               || ({{(CmpW-PixW){1'b0}}, pt_col} >= {{(CmpW-EW){1'b0}}, eff_w_q});

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_user_d  = m_user_q;
    if (out_free) begin
      m_valid_d = busy_q;
      m_data_d  = {color_q, pt_col, pt_row};
      m_last_d  = (k_q == 3'd7);
      m_user_d  = {fin_q, pt_out};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef ASSERT_OFF
  // a start always opens a fresh, non-final run at point zero
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (s_axis_tuser_i == OP_START) |=> busy_q && (k_q == 3'd0) && !fin_q)
    else $error("start did not open a new run");

  // while a run is emitting, a new transaction is taken only with its last point
  a_ready_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && s_axis_tready_o |-> (k_q == 3'd7) && out_free)
    else $error("input taken in the middle of a run");

  // the final iteration leaves the circle inactive
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && fin_q |-> !active_q)
    else $error("circle still active after final iteration");
`endif

endmodule
